### design/acm_pkg.sv
// ----------------------------------------------------------------------------
// Crosspoint mixer package
// Field widths, request codes and the command word passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package acm_pkg;

  localparam int unsigned CFG_W        = 6;
  localparam int unsigned CH_W         = 5;
  localparam int unsigned SMP_W        = 24;
  localparam int unsigned IDX_W        = 10;
  localparam int unsigned ACC_W        = 29;
  localparam int unsigned RESULT_LIMIT = 32;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 6'd8;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_READ   = 2'd2
  } req_e;

  typedef struct packed {
    req_e                     op;
    logic [IDX_W-1:0]         addr;
    logic                     route_on;
    logic                     in_range;
    logic                     ch_ok;
    logic                     last;
    logic signed [SMP_W-1:0]  sample;
  } cmd_t;

endpackage

`default_nettype wire

### design/acm_front.sv
// ----------------------------------------------------------------------------
// Crosspoint mixer front end
// Accepts request words, range-checks them against the channel count and
// pushes a command for every request that needs the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module acm_front (
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 req_type_i,
  input  logic [acm_pkg::CH_W-1:0]   channel_i,
  input  logic signed [acm_pkg::SMP_W-1:0] sample_value_i,
  input  logic                       last_in_frame_i,
  input  logic [acm_pkg::IDX_W-1:0]  route_index_i,
  input  logic                       route_on_i,
  input  logic [acm_pkg::CFG_W-1:0]  n_i,
  input  logic                       init_done_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output acm_pkg::cmd_t              q_cmd_o
);
  import acm_pkg::*;

  logic                   accept;
  logic                   ch_ok;
  logic                   in_range;
  logic [CH_W+CFG_W-1:0]  base;
  logic [CH_W+CFG_W-1:0]  lim;

  assign in_stall_o = !init_done_i || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    ch_ok    = {1'b0, channel_i} < n_i;
    base     = {{CFG_W{1'b0}}, channel_i} * {{CH_W{1'b0}}, n_i};
    lim      = {{CH_W{1'b0}}, n_i} * {{CH_W{1'b0}}, n_i};
    in_range = {{(CH_W+CFG_W-IDX_W){1'b0}}, route_index_i} < lim;

    q_cmd_o.op       = req_e'(req_type_i);
    q_cmd_o.addr     = route_index_i;
    q_cmd_o.route_on = route_on_i;
    q_cmd_o.in_range = in_range;
    q_cmd_o.ch_ok    = ch_ok;
    q_cmd_o.last     = last_in_frame_i;
    q_cmd_o.sample   = sample_value_i;
    q_push_o         = 1'b0;

    unique case (req_type_i) inside
      REQ_SAMPLE: begin
        q_cmd_o.addr = base[IDX_W-1:0];
        q_push_o     = accept;
      end
      REQ_READ: begin
        q_push_o = accept;
      end
      REQ_WRITE: begin
        q_push_o = accept && in_range;
      end
      default: begin
        q_push_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/acm_queue.sv
// ----------------------------------------------------------------------------
// Crosspoint mixer command queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module acm_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  acm_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output acm_pkg::cmd_t cmd_o
);
  import acm_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_q, wp_d;
  logic [PTR_W-1:0] rp_q, rp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = entry_q[rp_q];

  always_comb begin
    wp_d  = push_i ? wp_q + PTR_W'(1) : wp_q;
    rp_d  = pop_i ? rp_q + PTR_W'(1) : rp_q;
    cnt_d = cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wp_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

### design/acm_back.sv
// ----------------------------------------------------------------------------
// Crosspoint mixer back end
// Holds the route bit memory and the output accumulators, runs the sample
// sweep, the frame emit and the route reads, and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module acm_back #(
  parameter int unsigned NMAX = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [acm_pkg::CFG_W-1:0]         n_i,
  input  logic                              q_valid_i,
  input  acm_pkg::cmd_t                     q_cmd_i,
  output logic                              q_pop_o,
  output logic                              init_done_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [acm_pkg::CH_W-1:0]          out_channel_o,
  output logic signed [acm_pkg::SMP_W-1:0]  mix_value_o,
  output logic                              route_bit_o,
  output logic                              last_of_run_o
);
  import acm_pkg::*;

  localparam int unsigned DEPTH  = NMAX * NMAX;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned AIW    = $clog2(NMAX);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SAMPLE = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_EMIT   = 6'b010000,
    S_READ   = 6'b100000
  } state_e;

  state_e                   state_q, state_d;
  logic [CH_W-1:0]          o_q, o_d;
  logic [ADDR_W-1:0]        addr_q, addr_d;
  logic [ADDR_W-1:0]        clr_q, clr_d;
  logic                     last_q, last_d;
  logic signed [SMP_W-1:0]  smp_q, smp_d;
  logic                     hit_v_q, hit_v_d;
  logic [AIW-1:0]           hit_o_q, hit_o_d;
  logic                     rbit_ok_q, rbit_ok_d;
  logic                     rd_q;

  logic                     route_mem [DEPTH];
  logic                     mem_we, mem_wdata, mem_re;
  logic [ADDR_W-1:0]        mem_waddr, mem_raddr;

  logic signed [ACC_W-1:0]  acc_q [NMAX];
  logic [ACC_W:0]           acc_sum_w;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [ACC_W-1:0]  acc_rd;
  logic                     acc_clr;

  logic                     out_valid_q, out_valid_d;
  logic [CH_W-1:0]          out_ch_q, ld_ch;
  logic signed [SMP_W-1:0]  out_mix_q, ld_mix;
  logic                     out_bit_q, ld_bit;
  logic                     out_last_q, ld_last;
  logic                     out_free, out_load;
  logic                     o_last;

  assign init_done_o   = state_q != S_CLEAR;
  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign mix_value_o   = out_mix_q;
  assign route_bit_o   = out_bit_q;
  assign last_of_run_o = out_last_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign o_last   = {1'b0, o_q} == (n_i - CFG_W'(1));
  assign acc_rd   = acc_q[o_q[AIW-1:0]];

  always_comb begin
    acc_sum_w = {acc_q[hit_o_q][ACC_W-1], acc_q[hit_o_q]}
              + {{(ACC_W+1-SMP_W){smp_q[SMP_W-1]}}, smp_q};
    if (acc_sum_w[ACC_W] != acc_sum_w[ACC_W-1]) begin
      acc_sum = acc_sum_w[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sum = acc_sum_w[ACC_W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    o_d         = o_q;
    addr_d      = addr_q;
    clr_d       = clr_q;
    last_d      = last_q;
    smp_d       = smp_q;
    hit_v_d     = 1'b0;
    hit_o_d     = hit_o_q;
    rbit_ok_d   = rbit_ok_q;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = addr_q;
    q_pop_o     = 1'b0;
    acc_clr     = 1'b0;
    out_load    = 1'b0;
    ld_ch       = '0;
    ld_mix      = '0;
    ld_bit      = 1'b0;
    ld_last     = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = (clr_q == '0) || (32'(clr_q) == 32'd9);
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.op)
            REQ_WRITE: begin
              mem_we    = 1'b1;
              mem_waddr = ADDR_W'(q_cmd_i.addr);
              mem_wdata = q_cmd_i.route_on;
            end
            REQ_READ: begin
              mem_re    = q_cmd_i.in_range;
              mem_raddr = ADDR_W'(q_cmd_i.addr);
              rbit_ok_d = q_cmd_i.in_range;
              state_d   = S_READ;
            end
            REQ_SAMPLE: begin
              smp_d  = q_cmd_i.sample;
              last_d = q_cmd_i.last;
              o_d    = '0;
              addr_d = ADDR_W'(q_cmd_i.addr);
              if (q_cmd_i.ch_ok) begin
                state_d = S_SAMPLE;
              end else if (q_cmd_i.last) begin
                state_d = S_EMIT;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SAMPLE: begin
        mem_re  = 1'b1;
        hit_v_d = 1'b1;
        hit_o_d = o_q[AIW-1:0];
        addr_d  = addr_q + ADDR_W'(1);
        o_d     = o_q + CH_W'(1);
        if (o_last) begin
          o_d     = '0;
          state_d = last_q ? S_DRAIN : S_IDLE;
        end
      end
      S_DRAIN: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          acc_clr  = 1'b1;
          ld_ch    = o_q;
          ld_last  = o_last;
          if (acc_rd[ACC_W-1:SMP_W-1] == '0 || acc_rd[ACC_W-1:SMP_W-1] == '1) begin
            ld_mix = acc_rd[SMP_W-1:0];
          end else begin
            ld_mix = acc_rd[ACC_W-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
          end
          o_d = o_q + CH_W'(1);
          if (o_last) begin
            o_d     = '0;
            state_d = S_IDLE;
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_bit   = rbit_ok_q && rd_q;
          ld_last  = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      o_q         <= '0;
      addr_q      <= '0;
      clr_q       <= '0;
      last_q      <= 1'b0;
      hit_v_q     <= 1'b0;
      hit_o_q     <= '0;
      rbit_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      o_q         <= o_d;
      addr_q      <= addr_d;
      clr_q       <= clr_d;
      last_q      <= last_d;
      hit_v_q     <= hit_v_d;
      hit_o_q     <= hit_o_d;
      rbit_ok_q   <= rbit_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q <= smp_d;
    if (out_load) begin
      out_ch_q   <= ld_ch;
      out_mix_q  <= ld_mix;
      out_bit_q  <= ld_bit;
      out_last_q <= ld_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      route_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= route_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '{default: '0};
    end else begin
      if (hit_v_q && rd_q) begin
        acc_q[hit_o_q] <= acc_sum;
      end
      if (acc_clr) begin
        acc_q[o_q[AIW-1:0]] <= '0;
      end
    end
  end

  a_no_acc_during_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_v_q |-> state_q != S_EMIT)
    else $error("accumulate still pending while emitting");

  a_quiet_during_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !out_valid_q && !q_pop_o)
    else $error("activity during route clear");

  a_clear_complete : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(init_done_o) |-> $past(clr_q) == ADDR_W'(DEPTH - 1))
    else $error("route clear ended early");

endmodule

`default_nettype wire

### design/audio_crosspoint_mixer.sv
// ----------------------------------------------------------------------------
// Audio crosspoint mixer
// Flow: a route read passes the command queue, a route memory read and the
// output register; a sample sweeps its input's N crosspoints on the single read
// port, and a frame end adds a drain state and an emit of N words, one per
// output channel. The back end takes a new sample only after the sweep ends.
// Reset: a clear of all min(MAX_CHANNELS,32)^2 route memory entries (1024 at
// default) runs with in_stall_o high; routes 0->0 and 1->1 come up on.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_crosspoint_mixer #(
  parameter int unsigned MAX_CHANNELS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [acm_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        req_type_i,
  input  logic [acm_pkg::CH_W-1:0]          channel_i,
  input  logic signed [acm_pkg::SMP_W-1:0]  sample_value_i,
  input  logic                              last_in_frame_i,
  input  logic [acm_pkg::IDX_W-1:0]         route_index_i,
  input  logic                              route_on_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [acm_pkg::CH_W-1:0]          out_channel_o,
  output logic signed [acm_pkg::SMP_W-1:0]  mix_value_o,
  output logic                              route_bit_o,
  output logic                              last_of_run_o
);
  import acm_pkg::*;

  localparam int unsigned NMAX = (MAX_CHANNELS < RESULT_LIMIT) ? MAX_CHANNELS : RESULT_LIMIT;

  logic [CFG_W-1:0] num_channels_q;
  logic [CFG_W-1:0] n;
  logic             init_done;
  logic             q_full, q_push, q_valid, q_pop;
  cmd_t             push_cmd, pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_channels_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      num_channels_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (num_channels_q == '0) begin
      n = CFG_W'(1);
    end else if (num_channels_q > CFG_W'(NMAX)) begin
      n = CFG_W'(NMAX);
    end else begin
      n = num_channels_q;
    end
  end

  acm_front u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .channel_i       (channel_i),
    .sample_value_i  (sample_value_i),
    .last_in_frame_i (last_in_frame_i),
    .route_index_i   (route_index_i),
    .route_on_i      (route_on_i),
    .n_i             (n),
    .init_done_i     (init_done),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (push_cmd)
  );

  acm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (pop_cmd)
  );

  acm_back #(
    .NMAX (NMAX)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .n_i           (n),
    .q_valid_i     (q_valid),
    .q_cmd_i       (pop_cmd),
    .q_pop_o       (q_pop),
    .init_done_o   (init_done),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_channel_o (out_channel_o),
    .mix_value_o   (mix_value_o),
    .route_bit_o   (route_bit_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire
